/* sv/okrl_pkg.sv */
// ----------------------------------------------------------------------------
// okrl_pkg
// Shared types, codes and sizes of the ordered keyed record list.
// ----------------------------------------------------------------------------
package okrl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int CMD_W    = 4;
    localparam int ID_W     = 32;
    localparam int SCORE_W  = 12;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 3;

    typedef logic signed [ID_W-1:0] t_id;
    typedef logic [SCORE_W-1:0]     t_score;
    typedef logic [POS_W-1:0]       t_pos;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT    = 4'd0,
        CMD_ADD_BACK     = 4'd1,
        CMD_INSERT_AT    = 4'd2,
        CMD_POP_FRONT    = 4'd3,
        CMD_POP_BACK     = 4'd4,
        CMD_LOOKUP       = 4'd5,
        CMD_REMOVE_ID    = 4'd6,
        CMD_UPDATE_SCORE = 4'd7,
        CMD_REMOVE_BELOW = 4'd8
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_APPENDED  = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    // What every cell does in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } t_cell_mode;

    // Broadcast control to the row of cells.
    typedef struct packed {
        t_cell_mode mode;
        logic       tail_wr;
        t_pos       pos;
        t_id        id;
        t_score     score;
    } t_cell_ctl;

endpackage

/* sv/okrl_cell.sv */
// ----------------------------------------------------------------------------
// okrl_cell
// One list position: holds a record and takes its next value from itself,
// its left or right neighbor, or the broadcast record.
// ----------------------------------------------------------------------------
module okrl_cell #(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  okrl_pkg::t_cell_ctl i_ctl,
    input  okrl_pkg::t_id      i_left_id,
    input  okrl_pkg::t_score   i_left_score,
    input  okrl_pkg::t_id      i_right_id,
    input  okrl_pkg::t_score   i_right_score,
    output okrl_pkg::t_id      o_id,
    output okrl_pkg::t_score   o_score
);
    import okrl_pkg::*;

    localparam t_pos MY_POS = t_pos'(IDX);

    t_id    r_id;
    t_id    n_id;
    t_score r_score;
    t_score n_score;

    always_comb begin
        n_id    = r_id;
        n_score = r_score;
        case (i_ctl.mode)
            CELL_INSERT: begin
                if (i_ctl.pos == MY_POS) begin
                    n_id    = i_ctl.id;
                    n_score = i_ctl.score;
                end else if (MY_POS > i_ctl.pos) begin
                    n_id    = i_left_id;
                    n_score = i_left_score;
                end
            end
            CELL_SHIFT: begin
                // Everything moves one place toward the head; the tail slot
                // may take the record that just left the head.
                if (i_ctl.tail_wr && (i_ctl.pos == MY_POS)) begin
                    n_id    = i_ctl.id;
                    n_score = i_ctl.score;
                end else begin
                    n_id    = i_right_id;
                    n_score = i_right_score;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_score <= n_score;
    end

    assign o_id    = r_id;
    assign o_score = r_score;

endmodule

/* sv/okrl_ctrl.sv */
// ----------------------------------------------------------------------------
// okrl_ctrl
// Command sequencer: takes items, drives the cell row and holds the result.
// ----------------------------------------------------------------------------
module okrl_ctrl #(
    parameter int CAPACITY = okrl_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [okrl_pkg::CMD_W-1:0]     i_cmd,
    input  okrl_pkg::t_id                  i_id,
    input  okrl_pkg::t_score               i_score,
    input  okrl_pkg::t_pos                 i_index,
    input  okrl_pkg::t_id                  i_head_id,
    input  okrl_pkg::t_score               i_head_score,
    output okrl_pkg::t_cell_ctl            o_ctl,
    output logic                           o_valid,
    input  logic                           i_out_ready,
    output okrl_pkg::t_status              o_status,
    output okrl_pkg::t_id                  o_id,
    output okrl_pkg::t_score               o_score,
    output logic [CNT_W-1:0]               o_count
);
    import okrl_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state           r_state, n_state;
    t_cmd             r_cmd, n_cmd;
    t_id              r_id, n_id;
    t_score           r_score, n_score;
    t_pos             r_index, n_index;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic [CNT_W-1:0] r_len, n_len;
    logic             r_found, n_found;
    t_id              r_rid, n_rid;
    t_score           r_rscore, n_rscore;
    logic             r_out_valid, n_out_valid;
    t_status          r_out_status, n_out_status;
    t_id              r_out_id, n_out_id;
    t_score           r_out_score, n_out_score;
    logic [CNT_W-1:0] r_out_count, n_out_count;

    logic             w_out_free;
    logic             w_is_scan;
    logic             w_last;
    logic             w_first;
    logic             w_keep;
    logic             w_found_now;
    t_id              w_rid_now;
    t_score           w_rscore_now;
    t_score           w_tail_score;
    logic [CNT_W-1:0] w_len_now;
    logic             w_full;
    logic             w_empty;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_is_scan  = (r_cmd == CMD_LOOKUP) || (r_cmd == CMD_REMOVE_ID) ||
                        (r_cmd == CMD_UPDATE_SCORE) || (r_cmd == CMD_REMOVE_BELOW);
    assign w_last     = (r_left == CNT_W'(1));
    assign w_full     = (r_count == CNT_W'(CAPACITY));
    assign w_empty    = (r_count == '0);

    // One record leaves the head per scan step; the first id match is marked.
    assign w_first = (i_head_id == r_id) && !r_found;

    always_comb begin
        case (r_cmd)
            CMD_REMOVE_ID:    w_keep = !w_first;
            CMD_REMOVE_BELOW: w_keep = !(i_head_score < r_score);
            default:          w_keep = 1'b1;
        endcase
    end

    assign w_tail_score = ((r_cmd == CMD_UPDATE_SCORE) && w_first) ? r_score : i_head_score;
    assign w_found_now  = r_found || w_first;
    assign w_rid_now    = ((r_cmd == CMD_LOOKUP) && w_first) ? i_head_id : r_rid;
    assign w_rscore_now = ((r_cmd == CMD_LOOKUP) && w_first) ? i_head_score : r_rscore;
    assign w_len_now    = w_keep ? r_len : r_len - 1'b1;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_id         = r_id;
        n_score      = r_score;
        n_index      = r_index;
        n_count      = r_count;
        n_left       = r_left;
        n_len        = r_len;
        n_found      = r_found;
        n_rid        = r_rid;
        n_rscore     = r_rscore;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_score  = r_out_score;
        n_out_count  = r_out_count;

        o_ctl.mode    = CELL_HOLD;
        o_ctl.tail_wr = 1'b0;
        o_ctl.pos     = '0;
        o_ctl.id      = r_id;
        o_ctl.score   = r_score;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = t_cmd'(i_cmd);
                    n_id     = i_id;
                    n_score  = i_score;
                    n_index  = i_index;
                    n_left   = r_count;
                    n_len    = r_count;
                    n_found  = 1'b0;
                    n_rid    = '0;
                    n_rscore = '0;
                    n_state  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_is_scan && (r_left != '0)) begin
                    // The last step writes the result, so it waits for room in the output register.
                    if (!w_last || w_out_free) begin
                        o_ctl.mode    = CELL_SHIFT;
                        o_ctl.tail_wr = w_keep;
                        o_ctl.pos     = t_pos'(r_len - 1'b1);
                        o_ctl.id      = i_head_id;
                        o_ctl.score   = w_tail_score;
                        n_len    = w_len_now;
                        n_left   = r_left - 1'b1;
                        n_found  = w_found_now;
                        n_rid    = w_rid_now;
                        n_rscore = w_rscore_now;
                        if (w_last) begin
                            n_state      = S_IDLE;
                            n_out_valid  = 1'b1;
                            n_out_id     = w_rid_now;
                            n_out_score  = w_rscore_now;
                            n_out_count  = w_len_now;
                            n_count      = w_len_now;
                            if ((r_cmd == CMD_REMOVE_BELOW) || w_found_now) begin
                                n_out_status = ST_OK;
                            end else begin
                                n_out_status = ST_NOT_FOUND;
                            end
                        end
                    end
                end else if (w_out_free) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_id     = '0;
                    n_out_score  = '0;
                    n_out_count  = r_count;
                    case (r_cmd)
                        CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                o_ctl.mode  = CELL_INSERT;
                                n_out_count = r_count + 1'b1;
                                if (r_cmd == CMD_ADD_FRONT) begin
                                    o_ctl.pos = '0;
                                end else if (r_cmd == CMD_ADD_BACK) begin
                                    o_ctl.pos = t_pos'(r_count);
                                end else if (r_index == '0) begin
                                    o_ctl.pos = '0;
                                end else if (CMP_W'(r_index) >= CMP_W'(r_count)) begin
                                    o_ctl.pos    = t_pos'(r_count);
                                    n_out_status = ST_APPENDED;
                                end else begin
                                    o_ctl.pos = r_index;
                                end
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                o_ctl.mode  = CELL_SHIFT;
                                n_out_count = r_count - 1'b1;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_out_count = r_count - 1'b1;
                            end
                        end
                        CMD_LOOKUP, CMD_UPDATE_SCORE: begin
                            n_out_status = ST_NOT_FOUND;
                        end
                        CMD_REMOVE_ID, CMD_REMOVE_BELOW: begin
                            n_out_status = ST_EMPTY;
                        end
                        default: begin
                        end
                    endcase
                    n_count = n_out_count;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_cmd        <= n_cmd;
        r_id         <= n_id;
        r_score      <= n_score;
        r_index      <= n_index;
        r_left       <= n_left;
        r_len        <= n_len;
        r_found      <= n_found;
        r_rid        <= n_rid;
        r_rscore     <= n_rscore;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_score  <= n_out_score;
        r_out_count  <= n_out_count;
    end

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_id     = r_out_id;
    assign o_score  = r_out_score;
    assign o_count  = r_out_count;

endmodule

/* sv/ordered_keyed_record_list.sv */
// ----------------------------------------------------------------------------
// ordered_keyed_record_list
// Ordered list of id/score records built as a row of cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, position 0 at the head. An item
// is taken only while the block is idle (S_IDLE). Add, insert, pop and unused
// commands then finish in S_EXEC once the output register has room, since all
// cells update at once. Lookup, remove by id, update and remove below pass
// every held record once through the head cell and back to the tail, one
// record per cycle, the last step waiting for room in the output register;
// removed records are not written back. A new item is accepted while the
// previous result still waits in the output register.
module ordered_keyed_record_list #(
    parameter int CAPACITY = okrl_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((47 + CNT_W + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // command[3:0], in_id[35:4], in_score[47:36], in_index[55:48]
    input  logic [55:0]      i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // status[2:0], out_id[34:3], out_score[46:35], entry_count from bit 47, zero pad
    output logic [OUT_W-1:0] o_m_axis_tdata
);
    import okrl_pkg::*;

    t_cell_ctl        w_ctl;
    t_id              w_cell_id    [CAPACITY];
    t_score           w_cell_score [CAPACITY];
    t_status          w_status;
    t_id              w_out_id;
    t_score           w_out_score;
    logic [CNT_W-1:0] w_count;

    okrl_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_cmd        (i_s_axis_tdata[3:0]),
        .i_id         (i_s_axis_tdata[35:4]),
        .i_score      (i_s_axis_tdata[47:36]),
        .i_index      (i_s_axis_tdata[55:48]),
        .i_head_id    (w_cell_id[0]),
        .i_head_score (w_cell_score[0]),
        .o_ctl        (w_ctl),
        .o_valid      (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_status     (w_status),
        .o_id         (w_out_id),
        .o_score      (w_out_score),
        .o_count      (w_count)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_id    w_left_id;
        t_score w_left_score;
        t_id    w_right_id;
        t_score w_right_score;

        // The end cells see themselves where they have no neighbor.
        if (g == 0) begin : g_head
            assign w_left_id    = w_cell_id[g];
            assign w_left_score = w_cell_score[g];
        end else begin : g_mid_l
            assign w_left_id    = w_cell_id[g-1];
            assign w_left_score = w_cell_score[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_id    = w_cell_id[g];
            assign w_right_score = w_cell_score[g];
        end else begin : g_mid_r
            assign w_right_id    = w_cell_id[g+1];
            assign w_right_score = w_cell_score[g+1];
        end

        okrl_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_left_id     (w_left_id),
            .i_left_score  (w_left_score),
            .i_right_id    (w_right_id),
            .i_right_score (w_right_score),
            .o_id          (w_cell_id[g]),
            .o_score       (w_cell_score[g])
        );
    end

    assign o_m_axis_tdata = OUT_W'({w_count, w_out_score, w_out_id, w_status});

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_count <= CNT_W'(CAPACITY)))
        else $error("held count above capacity");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_status == ST_FULL)) |-> (w_count == CNT_W'(CAPACITY)))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_status == ST_EMPTY)) |-> (w_count == '0))
        else $error("empty status with records held");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_status != ST_OK)) |-> ((w_out_id == '0) && (w_out_score == '0)))
        else $error("record fields set on a failed command");

endmodule

/* test/tb_ordered_keyed_record_list.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_keyed_record_list
// Self-checking bench for the ordered keyed record list.
// ----------------------------------------------------------------------------
// A short table of directed commands covers the empty and boundary
// cases. Random phases then grow, shrink and search the list. Every command
// is run through a behavioral copy of the list when it is accepted, and each
// returned item is compared field by field with the oldest prediction. Both
// stream sides idle at random, the output side is held off for a long stretch
// twice, and the sender waits for the list to drain now and then.
// ----------------------------------------------------------------------------
module tb_ordered_keyed_record_list;
    import okrl_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int TOTAL_ITEMS = 1150;
    localparam int CALM_ITEMS  = 120;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int STALL_LIMIT = 2000;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 4'd15;

    typedef enum int {
        MIX_GROW,
        MIX_SHRINK,
        MIX_SEARCH,
        MIX_ANY
    } t_mix;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_id                 id;
        t_score              score;
        logic [4:0]          count;
    } t_result;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        t_id              id;
        t_score           score;
        t_pos             idx;
        logic             typed;
        t_result          want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    // command[3:0], in_id[35:4], in_score[47:36], in_index[55:48]
    logic [55:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    // status[2:0], out_id[34:3], out_score[46:35], entry_count[51:47], zero pad
    logic [55:0] o_m_axis_tdata;

    // Behavioral copy of the list.
    t_id     held_id    [0:CAP-1];
    t_score  held_score [0:CAP-1];
    int      held_n = 0;

    t_result pending_results [$];
    t_row    command_table [$];

    int n_sent = 0;
    int n_checked = 0;
    int n_errors = 0;
    int n_full = 0;
    int n_hits = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b0;
    bit hold_req = 1'b0;
    t_result seen, wanted;

    always #4 i_clk = ~i_clk;

    ordered_keyed_record_list dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    function automatic void drop_record(int at);
        int k;
        for (k = at; k < held_n - 1; k++) begin
            held_id[k]    = held_id[k + 1];
            held_score[k] = held_score[k + 1];
        end
        held_n--;
    endfunction

    // Applies one command to the copy of the list and returns its result.
    function automatic t_result list_apply(logic [CMD_W-1:0] cmd, t_id id, t_score sc,
                                           t_pos idx);
        t_result r;
        int pos, hit, k, w;
        r = '0;
        r.status = ST_OK;
        hit = held_n;
        for (k = held_n - 1; k >= 0; k--)
            if (held_id[k] == id)
                hit = k;
        case (cmd)
            CMD_ADD_FRONT, CMD_ADD_BACK, CMD_INSERT_AT: begin
                if (held_n >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    pos = held_n;
                    if (cmd == CMD_ADD_FRONT || (cmd == CMD_INSERT_AT && idx == 0))
                        pos = 0;
                    else if (cmd == CMD_INSERT_AT && idx < held_n)
                        pos = idx;
                    else if (cmd == CMD_INSERT_AT)
                        r.status = ST_APPENDED;
                    for (k = held_n; k > pos; k--) begin
                        held_id[k]    = held_id[k - 1];
                        held_score[k] = held_score[k - 1];
                    end
                    held_id[pos]    = id;
                    held_score[pos] = sc;
                    held_n++;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (held_n == 0)
                    r.status = ST_EMPTY;
                else
                    drop_record((cmd == CMD_POP_FRONT) ? 0 : held_n - 1);
            end
            CMD_LOOKUP: begin
                if (hit == held_n) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.id    = held_id[hit];
                    r.score = held_score[hit];
                end
            end
            CMD_REMOVE_ID: begin
                if (held_n == 0)
                    r.status = ST_EMPTY;
                else if (hit == held_n)
                    r.status = ST_NOT_FOUND;
                else
                    drop_record(hit);
            end
            CMD_UPDATE_SCORE: begin
                if (hit == held_n)
                    r.status = ST_NOT_FOUND;
                else
                    held_score[hit] = sc;
            end
            CMD_REMOVE_BELOW: begin
                if (held_n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    w = 0;
                    for (k = 0; k < held_n; k++) begin
                        if (held_score[k] >= sc) begin
                            held_id[w]    = held_id[k];
                            held_score[w] = held_score[k];
                            w++;
                        end
                    end
                    held_n = w;
                end
            end
            default: ;
        endcase
        r.count = 5'(held_n);
        return r;
    endfunction

    function automatic t_row tab_row(logic [CMD_W-1:0] cmd, t_id id, t_score sc, t_pos idx,
                                     logic typed, logic [STATUS_W-1:0] st, t_id rid,
                                     t_score rsc, logic [4:0] cnt);
        t_row rw;
        rw.cmd   = cmd;
        rw.id    = id;
        rw.score = sc;
        rw.idx   = idx;
        rw.typed = typed;
        rw.want  = {st, rid, rsc, cnt};
        return rw;
    endfunction

    // Offers one command and waits until it is taken; returns at the accepting edge.
    task automatic issue_command(input t_row rw);
        t_result exp_r;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {rw.idx, rw.score, rw.id, rw.cmd};
        do @(posedge i_clk); while (!o_s_axis_tready);
        exp_r = list_apply(rw.cmd, rw.id, rw.score, rw.idx);
        if (rw.typed)
            exp_r = rw.want;
        pending_results.push_back(exp_r);
        n_sent++;
        if (exp_r.status == ST_FULL)
            n_full++;
        if (rw.cmd == CMD_LOOKUP && exp_r.status == ST_OK)
            n_hits++;
    endtask

    // Drops tvalid for a number of cycles, or until every result is back if zero.
    task automatic hold_sender(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        if (cycles == 0) begin
            do @(posedge i_clk); while (pending_results.size() != 0);
        end else begin
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Sender.
    initial begin
        t_row rw;
        t_mix mix;
        int phase, len, i, r;
        bit gaps;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty list first, then extremes of id, score and index.
        command_table.push_back(tab_row(CMD_POP_FRONT, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        command_table.push_back(tab_row(CMD_POP_BACK, 0, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        command_table.push_back(tab_row(CMD_LOOKUP, 5, 0, 0, 1, ST_NOT_FOUND, 0, 0, 0));
        command_table.push_back(tab_row(CMD_REMOVE_ID, 5, 0, 0, 1, ST_EMPTY, 0, 0, 0));
        command_table.push_back(tab_row(CMD_UPDATE_SCORE, 5, 7, 0, 1, ST_NOT_FOUND, 0, 0, 0));
        command_table.push_back(tab_row(CMD_REMOVE_BELOW, 0, 12'hfff, 0, 1, ST_EMPTY, 0, 0, 0));
        command_table.push_back(tab_row(CMD_INSERT_AT, 32'h7fffffff, 12'hfff, 8'hff, 1,
                                        ST_APPENDED, 0, 0, 1));
        command_table.push_back(tab_row(CMD_ADD_FRONT, 32'h80000000, 0, 0, 1, ST_OK, 0, 0, 2));
        command_table.push_back(tab_row(CMD_ADD_BACK, 32'hffffffff, 12'h800, 8'h55, 1,
                                        ST_OK, 0, 0, 3));
        command_table.push_back(tab_row(CMD_INSERT_AT, 1, 12'h001, 0, 1, ST_OK, 0, 0, 4));
        // A duplicate id in the middle; searches must hit the one nearer the head.
        command_table.push_back(tab_row(CMD_INSERT_AT, 1, 12'h7ff, 2, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_LOOKUP, 1, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_UPDATE_SCORE, 1, 12'habc, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_LOOKUP, 1, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_REMOVE_ID, 1, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_LOOKUP, 1, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_LOOKUP, 32'h80000000, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_LOOKUP, 12345, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_REMOVE_ID, 12345, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_SPARE_LO, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_SPARE_HI, 32'hffffffff, 12'hfff, 8'hff, 0,
                                        ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_REMOVE_BELOW, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        // A score equal to the threshold stays.
        command_table.push_back(tab_row(CMD_REMOVE_BELOW, 0, 12'h800, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_POP_BACK, 0, 0, 0, 0, ST_OK, 0, 0, 0));
        command_table.push_back(tab_row(CMD_POP_FRONT, 0, 0, 0, 0, ST_OK, 0, 0, 0));

        idle_on = 1'b1;
        foreach (command_table[j]) begin
            issue_command(command_table[j]);
            if ($urandom_range(0, 4) == 0)
                hold_sender($urandom_range(1, 6));
        end
        hold_sender(0);

        phase = 0;
        while (n_sent < TOTAL_ITEMS) begin
            mix  = (phase == 0) ? MIX_GROW : t_mix'($urandom_range(0, 3));
            len  = $urandom_range(40, 120);
            gaps = ($urandom_range(0, 3) != 0);
            if (phase == 1 || phase == 6)
                hold_req = 1'b1;
            for (i = 0; i < len && n_sent < TOTAL_ITEMS; i++) begin
                idle_on = gaps && (n_sent < TOTAL_ITEMS - CALM_ITEMS);
                rw = '0;

                r = $urandom_range(0, 99);
                case (mix)
                    MIX_GROW:
                        rw.cmd = (r < 30) ? CMD_ADD_FRONT : (r < 55) ? CMD_ADD_BACK :
                                 (r < 85) ? CMD_INSERT_AT : 4'($urandom_range(0, 15));
                    MIX_SHRINK:
                        rw.cmd = (r < 20) ? CMD_POP_FRONT : (r < 40) ? CMD_POP_BACK :
                                 (r < 65) ? CMD_REMOVE_ID : (r < 75) ? CMD_REMOVE_BELOW :
                                 (r < 85) ? CMD_ADD_BACK : 4'($urandom_range(0, 15));
                    MIX_SEARCH:
                        rw.cmd = (r < 35) ? CMD_LOOKUP : (r < 55) ? CMD_UPDATE_SCORE :
                                 (r < 65) ? CMD_REMOVE_ID : (r < 85) ? CMD_ADD_BACK :
                                 (r < 95) ? CMD_INSERT_AT :
                                 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                    default:
                        rw.cmd = (r < 6) ? 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)) :
                                 4'($urandom_range(0, 8));
                endcase

                // Ids mostly come from the list or a small pool so that searches hit
                // and duplicates build up.
                r = $urandom_range(0, 7);
                if (r < 3 && held_n > 0)
                    rw.id = held_id[$urandom_range(0, held_n - 1)];
                else if (r < 6)
                    rw.id = $urandom_range(0, 5);
                else
                    rw.id = $urandom;

                r = $urandom_range(0, 9);
                if (r == 0)
                    rw.score = '0;
                else if (r == 1)
                    rw.score = '1;
                else if (r < 5 && held_n > 0)
                    rw.score = held_score[$urandom_range(0, held_n - 1)];
                else
                    rw.score = $urandom_range(0, 4095);

                if ($urandom_range(0, 5) == 0)
                    rw.idx = $urandom_range(0, 255);
                else
                    rw.idx = $urandom_range(0, held_n + 1);

                issue_command(rw);
                if (i == len - 1 && (n_sent < TOTAL_ITEMS - CALM_ITEMS) &&
                    (phase == 2 || $urandom_range(0, 2) == 0))
                    hold_sender(0);
                else if (idle_on && $urandom_range(0, 5) == 0)
                    hold_sender($urandom_range(1, 6));
            end
            phase++;
        end

        idle_on = 1'b0;
        hold_sender(0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Sent %0d commands (%0d directed) and checked %0d results.",
                 n_sent, command_table.size(), n_checked);
        $display("The list was found full %0d times and %0d lookups found a record.",
                 n_full, n_hits);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random short stalls, plus one long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            seen.status = o_m_axis_tdata[2:0];
            seen.id     = o_m_axis_tdata[34:3];
            seen.score  = o_m_axis_tdata[46:35];
            seen.count  = o_m_axis_tdata[51:47];
            if (pending_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with none expected: status %0d id %0d score 0x%03h count %0d",
                         $time, seen.status, seen.id, seen.score, seen.count);
            end else begin
                wanted = pending_results.pop_front();
                n_checked++;
                if (seen.status !== wanted.status || seen.id !== wanted.id ||
                    seen.score !== wanted.score || seen.count !== wanted.count) begin
                    n_errors++;
                    $display("%0t: expected status %0d id %0d score 0x%03h count %0d",
                             $time, wanted.status, wanted.id, wanted.score, wanted.count);
                    $display("%0t:   actual status %0d id %0d score 0x%03h count %0d",
                             $time, seen.status, seen.id, seen.score, seen.count);
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, pending_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

/* ordered_keyed_record_list.f */
sv/okrl_pkg.sv
sv/okrl_cell.sv
sv/okrl_ctrl.sv
sv/ordered_keyed_record_list.sv
test/tb_ordered_keyed_record_list.sv
